// ----- rtl/core/esfb_pkg.sv -----
// Shared types, constants and functions of the encrypted sensor frame builder.
// No dependencies; every other file of the block refers to it by scoped names.
package esfb_pkg;

    localparam int unsigned FRAME_LEN   = 21;
    localparam int unsigned PAYLOAD_LEN = 16;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned PAY_IDX_W   = 4;

    localparam logic [7:0]  NET_BYTE      = 8'hA1;
    localparam logic [7:0]  PAD_BYTE      = 8'h00;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [31:0] SEED_ZERO_SUB = 32'hA5A5A5A5;

    localparam logic [31:0] KEY_RESET   = 32'h496F5432;
    localparam logic [7:0]  ID_RESET    = 8'h01;
    localparam logic [15:0] NONCE_RESET = 16'h0000;

    // frame positions
    localparam logic [POS_W-1:0] POS_NET       = 5'd0;
    localparam logic [POS_W-1:0] POS_NONCE_LO  = 5'd1;
    localparam logic [POS_W-1:0] POS_NONCE_HI  = 5'd2;
    localparam logic [POS_W-1:0] POS_PAY_FIRST = 5'd3;
    localparam logic [POS_W-1:0] POS_CRC_LO    = 5'd19;
    localparam logic [POS_W-1:0] POS_LAST      = 5'd20;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY_WORD    = 2'd0,
        REG_SENSOR_ID   = 2'd1,
        REG_START_NONCE = 2'd2
    } esfb_reg_idx_t;

    typedef struct packed {
        logic        load;
        logic        step;
    } esfb_gen_ctrl_t;

    typedef struct packed {
        logic        init;
        logic        feed;
        logic [7:0]  data;
    } esfb_crc_ctrl_t;

    // one xorshift32 (13/17/5) step
    function automatic logic [31:0] xorshift_step(input logic [31:0] x);
        logic [31:0] v;
        v = x;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // CRC16 Modbus update by one byte, reflected, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/esfb_if.sv -----
// Channel interfaces of the frame builder: sample input, frame byte output
// and configuration write. Depends on esfb_pkg for the register index type.
interface esfb_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature;
    logic [15:0]        humidity;
    logic [10:0]        pressure;
    logic [16:0]        lux;

    modport source (output valid, temperature, humidity, pressure, lux, input ready);
    modport sink   (input valid, temperature, humidity, pressure, lux, output ready);
endinterface

interface esfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       last;

    modport source (output valid, frame_byte, byte_index, last, input ready);
    modport sink   (input valid, frame_byte, byte_index, last, output ready);
endinterface

interface esfb_cfg_if;
    logic                   valid;
    logic                   ready;
    esfb_pkg::esfb_reg_idx_t index;
    logic [31:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/esfb_prng.sv -----
// Keystream generator: xorshift32 state register, seeded per frame.
// Depends on esfb_pkg.
module esfb_prng (
    input  logic                     clk,
    input  logic                     rst_n,
    input  esfb_pkg::esfb_gen_ctrl_t ctrl,
    input  logic [31:0]              seed,
    output logic [7:0]               key_byte
);

    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [31:0] stepped;

    assign stepped  = esfb_pkg::xorshift_step(word_reg);
    assign key_byte = stepped[7:0];

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            word_next = (seed == 32'h0) ? esfb_pkg::SEED_ZERO_SUB : seed;
        end
        else if (ctrl.step)
        begin
            word_next = stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= 32'h0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ----- rtl/core/esfb_crc.sv -----
// CRC16 Modbus accumulator, one byte per cycle.
// Depends on esfb_pkg.
module esfb_crc (
    input  logic                     clk,
    input  logic                     rst_n,
    input  esfb_pkg::esfb_crc_ctrl_t ctrl,
    output logic [15:0]              crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    assign crc = crc_reg;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.init)
        begin
            crc_next = esfb_pkg::CRC_INIT;
        end
        else if (ctrl.feed)
        begin
            crc_next = esfb_pkg::crc16_byte(crc_reg, ctrl.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= esfb_pkg::CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

// ----- rtl/core/encrypted_sensor_frame_builder_core.sv -----
// Encrypted sensor frame builder, top level. Uses esfb_pkg, the channel
// interfaces of esfb_if, and the esfb_prng and esfb_crc units.
//
// One sample transaction on "sample" produces 21 output transactions on
// "frame": network byte 0xA1, the nonce low then high byte, 16 payload bytes
// (id, temperature LE32 sign-extended, humidity LE16, pressure LE32, lux LE32,
// zero pad) each XORed with the low byte of the next xorshift32 word, then the
// CRC16 Modbus of bytes 0..18, low byte first, with last set on byte 20.
// The sequencer hands out one byte per cycle while the output register is
// empty or being drained (the generator is seeded and the CRC cleared at the
// accepting edge itself), paced by the single generator and the single
// byte-wide CRC unit. sample.ready is high only while no frame is being
// built; the next sample can be taken while the final CRC byte still sits
// in the output register. cfg.ready is always high; writes are meant for
// idle periods only. Writing start_nonce loads the running nonce, which
// otherwise steps by one (wrapping) per frame.
module encrypted_sensor_frame_builder_core (
    input  logic              clk,
    input  logic              rst_n,
    esfb_in_if.sink           sample,
    esfb_out_if.source        frame,
    esfb_cfg_if.sink          cfg
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                         state_reg, state_next;
    logic [esfb_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [15:0]                    nonce_reg, nonce_next;
    logic [31:0]                    key_reg, key_next;
    logic [7:0]                     id_reg, id_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_byte_reg, out_byte_next;
    logic [esfb_pkg::POS_W-1:0]     out_idx_reg, out_idx_next;
    logic                           out_last_reg, out_last_next;

    // payload bytes of the frame in flight, filled on sample acceptance
    logic [7:0] payload_reg [esfb_pkg::PAYLOAD_LEN];

    logic        sample_take;
    logic        emit;
    logic        in_payload;
    logic [esfb_pkg::POS_W-1:0]     pay_off;
    logic [esfb_pkg::PAY_IDX_W-1:0] pay_idx;
    logic [7:0]  key_byte;
    logic [15:0] crc;
    logic [7:0]  cur_byte;
    logic [31:0] temp_ext;
    logic [31:0] pres_ext;
    logic [31:0] lux_ext;

    esfb_pkg::esfb_gen_ctrl_t gen_ctrl;
    esfb_pkg::esfb_crc_ctrl_t crc_ctrl;

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign sample_take  = sample.valid && sample.ready;

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.byte_index = out_idx_reg;
    assign frame.last       = out_last_reg;

    // a byte moves into the output register when it is empty or being drained
    assign emit = (state_reg == ST_RUN) && (!out_valid_reg || frame.ready);

    assign in_payload = (pos_reg >= esfb_pkg::POS_PAY_FIRST) &&
                        (pos_reg < esfb_pkg::POS_CRC_LO);
    assign pay_off    = pos_reg - esfb_pkg::POS_PAY_FIRST;
    assign pay_idx    = pay_off[esfb_pkg::PAY_IDX_W-1:0];

    assign temp_ext = {{17{sample.temperature[14]}}, sample.temperature};
    assign pres_ext = {21'h0, sample.pressure};
    assign lux_ext  = {15'h0, sample.lux};

    // generator: reseed on acceptance, one step per payload byte
    assign gen_ctrl.load = sample_take;
    assign gen_ctrl.step = emit && in_payload;

    esfb_prng u_prng (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (gen_ctrl),
        .seed     (key_reg ^ {nonce_reg, nonce_reg}),
        .key_byte (key_byte)
    );

    // CRC covers every byte before the CRC field
    assign crc_ctrl.init = sample_take;
    assign crc_ctrl.feed = emit && (pos_reg < esfb_pkg::POS_CRC_LO);
    assign crc_ctrl.data = cur_byte;

    esfb_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .crc   (crc)
    );

    // byte at the current frame position
    always_comb
    begin
        if (pos_reg == esfb_pkg::POS_NET)
        begin
            cur_byte = esfb_pkg::NET_BYTE;
        end
        else if (pos_reg == esfb_pkg::POS_NONCE_LO)
        begin
            cur_byte = nonce_reg[7:0];
        end
        else if (pos_reg == esfb_pkg::POS_NONCE_HI)
        begin
            cur_byte = nonce_reg[15:8];
        end
        else if (in_payload)
        begin
            cur_byte = payload_reg[pay_idx] ^ key_byte;
        end
        else if (pos_reg == esfb_pkg::POS_CRC_LO)
        begin
            cur_byte = crc[7:0];
        end
        else
        begin
            cur_byte = crc[15:8];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        nonce_next     = nonce_reg;
        key_next       = key_reg;
        id_next        = id_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;

        if (frame.valid && frame.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                esfb_pkg::REG_KEY_WORD:    key_next   = cfg.data;
                esfb_pkg::REG_SENSOR_ID:   id_next    = cfg.data[7:0];
                esfb_pkg::REG_START_NONCE: nonce_next = cfg.data[15:0];
                default:                   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_take)
                begin
                    state_next = ST_RUN;
                    pos_next   = esfb_pkg::POS_NET;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cur_byte;
                    out_idx_next   = pos_reg;
                    out_last_next  = (pos_reg == esfb_pkg::POS_LAST);
                    if (pos_reg == esfb_pkg::POS_LAST)
                    begin
                        state_next = ST_IDLE;
                        pos_next   = esfb_pkg::POS_NET;
                        nonce_next = nonce_reg + 16'd1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= esfb_pkg::POS_NET;
            nonce_reg     <= esfb_pkg::NONCE_RESET;
            key_reg       <= esfb_pkg::KEY_RESET;
            id_reg        <= esfb_pkg::ID_RESET;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_idx_reg   <= esfb_pkg::POS_NET;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            nonce_reg     <= nonce_next;
            key_reg       <= key_next;
            id_reg        <= id_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_idx_reg   <= out_idx_next;
            out_last_reg  <= out_last_next;
        end
    end

    // payload capture, little-endian fields
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            payload_reg[0]  <= id_reg;
            payload_reg[1]  <= temp_ext[7:0];
            payload_reg[2]  <= temp_ext[15:8];
            payload_reg[3]  <= temp_ext[23:16];
            payload_reg[4]  <= temp_ext[31:24];
            payload_reg[5]  <= sample.humidity[7:0];
            payload_reg[6]  <= sample.humidity[15:8];
            payload_reg[7]  <= pres_ext[7:0];
            payload_reg[8]  <= pres_ext[15:8];
            payload_reg[9]  <= pres_ext[23:16];
            payload_reg[10] <= pres_ext[31:24];
            payload_reg[11] <= lux_ext[7:0];
            payload_reg[12] <= lux_ext[15:8];
            payload_reg[13] <= lux_ext[23:16];
            payload_reg[14] <= lux_ext[31:24];
            payload_reg[15] <= esfb_pkg::PAD_BYTE;
        end
    end

endmodule

// ----- test/esfb_frame_checker.sv -----
// Frame checker for the encrypted sensor frame builder: follows register writes
// and sample transactions, predicts every 21-byte frame and checks the output.
// Depends on esfb_pkg and the channel interfaces in esfb_if.
`timescale 1ns / 1ps

module esfb_frame_checker
    import esfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    esfb_in_if   sample,
    esfb_out_if  frame,
    esfb_cfg_if  cfg,
    output int   fail_count,
    output int   bytes_due,
    output int   bytes_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } frame_byte_t;

    // predictor state, mirrors the block's registers
    logic [31:0] key_word;
    logic [7:0]  sensor_id;
    logic [15:0] nonce_count;

    frame_byte_t frame_bytes_due[$];

    // builds the whole frame for one sample and queues its bytes
    function automatic void predict_frame(input logic [14:0] temp, input logic [15:0] hum,
                                          input logic [10:0] pres, input logic [16:0] lux);
        logic [7:0]       plain [PAYLOAD_LEN];
        logic [31:0]      temp32;
        logic [31:0]      word;
        logic [15:0]      crc;
        logic [7:0]       b;
        logic [POS_W-1:0] pos;
        frame_byte_t      e;
        int               i;
        int               k;

        temp32 = {{17{temp[14]}}, temp};
        plain[0] = sensor_id;
        {plain[4], plain[3], plain[2], plain[1]} = temp32;
        plain[5] = hum[7:0];
        plain[6] = hum[15:8];
        {plain[10], plain[9], plain[8], plain[7]} = {21'd0, pres};
        {plain[14], plain[13], plain[12], plain[11]} = {15'd0, lux};
        plain[15] = PAD_BYTE;

        word = key_word ^ {nonce_count, nonce_count};
        if (word == 32'd0)
            word = SEED_ZERO_SUB;
        crc = CRC_INIT;

        for (i = 0; i < FRAME_LEN; i++)
        begin
            pos = POS_W'(i);
            if (pos == POS_NET)
                b = NET_BYTE;
            else if (pos == POS_NONCE_LO)
                b = nonce_count[7:0];
            else if (pos == POS_NONCE_HI)
                b = nonce_count[15:8];
            else if (pos < POS_CRC_LO)
            begin
                // xorshift32, shifts 13 / 17 / 5
                word = word ^ (word << 13);
                word = word ^ (word >> 17);
                word = word ^ (word << 5);
                b = plain[i - int'(POS_PAY_FIRST)] ^ word[7:0];
            end
            else if (pos == POS_CRC_LO)
                b = crc[7:0];
            else
                b = crc[15:8];

            if (pos < POS_CRC_LO)
            begin
                crc = crc ^ {8'h00, b};
                for (k = 0; k < 8; k++)
                    crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end

            e.data = b;
            e.pos  = pos;
            e.last = (pos == POS_LAST);
            frame_bytes_due.push_back(e);
        end

        nonce_count = nonce_count + 16'd1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_byte_t want;
        if (!rst_n)
        begin
            key_word      = KEY_RESET;
            sensor_id     = ID_RESET;
            nonce_count   = NONCE_RESET;
            frame_bytes_due.delete();
            fail_count    = 0;
            bytes_due     = 0;
            bytes_checked = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KEY_WORD:    key_word    = cfg.data;
                    REG_SENSOR_ID:   sensor_id   = cfg.data[7:0];
                    REG_START_NONCE: nonce_count = cfg.data[15:0];
                    default: ;
                endcase
            end

            if (sample.valid && sample.ready)
                predict_frame(sample.temperature, sample.humidity, sample.pressure, sample.lux);

            if (frame.valid && frame.ready)
            begin
                bytes_checked++;
                if (frame_bytes_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected frame byte %02h index %0d last %0b",
                                 $realtime, frame.frame_byte, frame.byte_index, frame.last);
                end
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (frame.frame_byte !== want.data || frame.byte_index !== want.pos ||
                        frame.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: frame byte mismatch: exp %02h/%0d/%0b got %02h/%0d/%0b",
                                     $realtime, want.data, want.pos, want.last,
                                     frame.frame_byte, frame.byte_index, frame.last);
                    end
                end
            end

            bytes_due = frame_bytes_due.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the frame builder testbench: clock, reset, sample and register stimulus,
// random output back-pressure, watchdog and verdict. Depends on esfb_pkg, esfb_if,
// the block's top level and esfb_frame_checker.
`timescale 1ns / 1ps

module tb_top;
    import esfb_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 25;    // settle wait at the end of drain_frames
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any transaction
    localparam int IDLE_PCT        = 8;
    localparam int MAX_GAP         = 24;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int CALM_PHASE      = 2;     // this phase runs with no idling at all

    // index just past the register list; the block must drop such writes
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    bit   calm;

    int fail_count;
    int bytes_due;
    int bytes_checked;
    int samples_taken;
    int reg_writes;
    int settings_used;
    int idle_cycles;

    esfb_in_if  sample_ch ();
    esfb_out_if frame_ch ();
    esfb_cfg_if cfg_ch ();

    encrypted_sensor_frame_builder_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .frame  (frame_ch),
        .cfg    (cfg_ch)
    );

    esfb_frame_checker frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample_ch),
        .frame         (frame_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .bytes_due     (bytes_due),
        .bytes_checked (bytes_checked)
    );

    always #10 clk = ~clk;

    // Output back-pressure: ready drops in about 8% of cycles, never in the calm phase.
    always @(posedge clk)
        frame_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog: any transaction on any channel resets the count of dead cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((sample_ch.valid && sample_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles <= 0;
            if (sample_ch.valid && sample_ch.ready)
                samples_taken <= samples_taken + 1;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transaction", idle_cycles);
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one sample and hold it until the block takes it. Valid is left high so
    // that back-to-back samples never see a low/high pair in the same step; it only
    // drops for a random idle gap or in drain_frames.
    task automatic send_sample(input logic [14:0] temp, input logic [15:0] hum,
                               input logic [10:0] pres, input logic [16:0] lux);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.temperature <= temp;
        sample_ch.humidity    <= hum;
        sample_ch.pressure    <= pres;
        sample_ch.lux         <= lux;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Mostly realistic temperatures, a quarter of them any 15-bit pattern.
    task automatic send_random_sample();
        logic [14:0] temp;
        if ($urandom_range(3) == 0)
            temp = 15'($urandom);
        else
            temp = 15'(int'($urandom_range(12500)) - 4000);
        send_sample(temp, 16'($urandom), 11'($urandom), 17'($urandom));
    endtask

    task automatic write_reg(input esfb_reg_idx_t idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        reg_writes++;
    endtask

    // One register setting; full 32-bit data everywhere so the width masking is hit.
    task automatic program_regs(input logic [31:0] key, input logic [31:0] id_data,
                                input logic [31:0] nonce_data, input bit load_nonce,
                                input bit poke_unused);
        write_reg(REG_KEY_WORD, key);
        write_reg(REG_SENSOR_ID, id_data);
        if (load_nonce)
            write_reg(REG_START_NONCE, nonce_data);
        if (poke_unused)
            write_reg(esfb_reg_idx_t'(REG_UNUSED), $urandom);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Stop offering samples, wait for every predicted byte, then let the block settle.
    // The count is read on the falling edge, clear of the checker's update.
    task automatic drain_frames();
        sample_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (bytes_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          phase_idx;
        int          item_idx;
        int          key_kind;
        logic [31:0] key;
        logic [15:0] nonce;

        clk                   = 1'b0;
        rst_n                 = 1'b0;
        calm                  = 1'b0;
        samples_taken         = 0;
        reg_writes            = 0;
        settings_used         = 0;
        sample_ch.valid       = 1'b0;
        sample_ch.temperature = '0;
        sample_ch.humidity    = '0;
        sample_ch.pressure    = '0;
        sample_ch.lux         = '0;
        frame_ch.ready        = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_KEY_WORD;
        cfg_ch.data           = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset register values: field extremes, out-of-range temperatures
        // (any 15-bit pattern is sign-extended), alternating bit patterns.
        send_sample(15'(0), 16'h0000, 11'h000, 17'h00000);
        send_sample(15'(8500), 16'hFFFF, 11'h7FF, 17'h1FFFF);
        send_sample(15'(-4000), 16'h0000, 11'h000, 17'h00000);
        send_sample(15'(16383), 16'h5555, 11'h2AA, 17'h15555);
        send_sample(15'(-16384), 16'hAAAA, 11'h555, 17'h0AAAA);
        send_sample(15'(-1), 16'h0001, 11'h001, 17'h00001);
        send_sample(15'(1), 16'h8000, 11'h400, 17'h10000);
        drain_frames();

        // Key zero with nonce zero gives a zero seed, replaced by the fixed pattern.
        // Also a write past the register list, which must change nothing.
        program_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);
        send_sample(15'(2500), 16'h1234, 11'h3F2, 17'h0ABCD);
        send_sample(15'(-250), 16'hFEDC, 11'h0C1, 17'h1F00F);
        drain_frames();

        // All-ones key against nonce 0xFFFF: zero seed again, then the nonce wraps.
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_sample(15'(0), 16'hFFFF, 11'h7FF, 17'h1FFFF);
        send_sample(15'(8500), 16'h0000, 11'h000, 17'h00000);
        send_sample(15'(-4000), 16'h7FFF, 11'h3FF, 17'h0FFFF);
        drain_frames();

        // Random phases, each with a fresh register setting. The nonce is not always
        // reloaded, so the running count is also carried across settings.
        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++)
        begin
            nonce    = 16'($urandom);
            if ($urandom_range(3) == 0)
                nonce = 16'hFFFF - 16'($urandom_range(3));
            key_kind = $urandom_range(5);
            case (key_kind)
                0:       key = 32'h0000_0000;
                1:       key = 32'hFFFF_FFFF;
                2:       key = {nonce, nonce};  // zero seed on the first frame
                default: key = $urandom;
            endcase
            program_regs(key, $urandom, {16'($urandom), nonce},
                         key_kind == 2 || $urandom_range(3) != 0, $urandom_range(1) == 1);

            calm <= (phase_idx == CALM_PHASE);
            for (item_idx = 0; item_idx < ITEMS_PER_PHASE; item_idx++)
                send_random_sample();
            drain_frames();
        end

        $display("run covered %0d samples, %0d frame bytes checked", samples_taken, bytes_checked);
        $display("over %0d register settings (%0d writes, incl. out-of-list index)",
                 settings_used, reg_writes);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
